/* hdl/pcr_pkg.sv */
// Package for the phrase capture/replay ring: operation codes, register
// indexes, default geometry, handshake structs and the mod-7 helper.
// No dependencies.
package pcr_pkg;

    localparam int RING_DEPTH_DEF      = 4;
    localparam int STEPS_PER_BAR_DEF   = 16;
    localparam int BARS_PER_PHRASE_DEF = 4;

    localparam logic [7:0]  NO_NOTE         = 8'hFF;
    localparam logic [15:0] MIN_GAP_RESET   = 16'd30;
    localparam logic [8:0]  CHANCE_RESET    = 9'd64;
    localparam logic [15:0] GAP_MAX         = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_QUERY  = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic {
        REG_MIN_GAP = 1'b0,
        REG_CHANCE  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        SHIFT_NONE_A = 2'd0,
        SHIFT_NONE_B = 2'd1,
        SHIFT_UP     = 2'd2,
        SHIFT_DOWN   = 2'd3
    } shift_code_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;         // input beat accepted this cycle
        logic load_direct;  // load result register from a non-query beat
        logic load_lookup;  // load result register from the memory lookup
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_query;
    } stat_t;

    // configuration write from the bus decoder
    typedef struct packed {
        logic        we;
        reg_idx_t    idx;
        logic [31:0] data;
    } cfg_wr_t;

    // x mod 7 by octal digit sums (8 == 1 mod 7)
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

/* hdl/pcr_ctrl.sv */
// Controller for the phrase ring: handshake, lookup sequencing and the
// result-register valid flag. Depends on pcr_pkg.
module pcr_ctrl
    import pcr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    output logic  m_tvalid,
    input  logic  m_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.exec && stat.is_query) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        cmd.load_lookup = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = !out_valid_reg || m_tready;
            end
            ST_LOOKUP: begin
                cmd.load_lookup = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
        cmd.exec        = s_tvalid && s_tready;
        cmd.load_direct = cmd.exec && !stat.is_query;
        if (cmd.load_direct || cmd.load_lookup) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
        m_tvalid = out_valid_reg;
    end

endmodule

/* hdl/pcr_datapath.sv */
// Datapath for the phrase ring: phrase memory with per-slot valid marks,
// capture/replay state, configuration registers and the result register.
// Depends on pcr_pkg.
module pcr_datapath
    import pcr_pkg::*;
#(
    parameter int RING_DEPTH      = RING_DEPTH_DEF,
    parameter int STEPS_PER_BAR   = STEPS_PER_BAR_DEF,
    parameter int BARS_PER_PHRASE = BARS_PER_PHRASE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  in_op,
    input  logic [7:0]  in_step,
    input  logic [7:0]  in_degree,
    input  logic [31:0] in_rng,
    input  cfg_wr_t     cfg_wr,
    output logic [15:0] min_gap,
    output logic [8:0]  chance,
    output logic [7:0]  out_note,
    output logic        out_replaying
);

    localparam int PS     = STEPS_PER_BAR * BARS_PER_PHRASE;
    localparam int TOTAL  = RING_DEPTH * PS;
    localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int OFF_W  = (PS > 1) ? $clog2(PS) : 1;
    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int BAR_W  = $clog2(BARS_PER_PHRASE + 1);

    logic [7:0]       mem [TOTAL];
    logic [PS-1:0]    valid_reg [RING_DEPTH];

    logic [15:0]      min_gap_reg, chance_dummy_unused;
    logic [8:0]       chance_reg;
    logic [IDX_W-1:0] cap_idx_reg, cap_idx_next;
    logic [BAR_W-1:0] cap_bar_reg, cap_bar_next;
    logic [15:0]      gap_reg, gap_next;
    logic             active_reg, active_next;
    logic [IDX_W-1:0] rep_idx_reg, rep_idx_next;
    logic signed [2:0] rep_shift_reg, rep_shift_next;
    logic [BAR_W-1:0] rep_bar_reg, rep_bar_next;

    // lookup pipeline
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic             hit_reg;
    logic signed [2:0] lk_shift_reg;

    logic [7:0]       note_reg;
    logic             replaying_reg;

    op_t              op;
    logic             step_ok;
    logic             rec_en, query_en, tick_en;
    logic             clear_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [OFF_W-1:0]  wr_off, rd_off;
    logic             rd_hit;
    logic [BAR_W-1:0] cap_bar_inc, rep_bar_inc;
    logic [IDX_W-1:0] cap_idx_adv, pick, pick_adj;
    logic [8:0]       lk_sum;
    logic [7:0]       lk_note;

    assign chance_dummy_unused = 16'd0;

    function automatic logic [IDX_W-1:0] ring_mod(input logic [7:0] v);
        logic [4:0] r;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            r = {r[3:0], v[i]};
            if (r >= 5'(RING_DEPTH)) begin
                r = r - 5'(RING_DEPTH);
            end
        end
        return IDX_W'(r);
    endfunction

    assign op            = op_t'(in_op);
    assign stat.is_query = (op == OP_QUERY);
    assign step_ok       = in_step < 8'(STEPS_PER_BAR);

    assign rec_en   = cmd.exec && (op == OP_RECORD) && !active_reg && step_ok
                      && (cap_bar_reg < BAR_W'(BARS_PER_PHRASE));
    assign query_en = cmd.exec && (op == OP_QUERY);
    assign tick_en  = cmd.exec && (op == OP_TICK);

    assign wr_off  = OFF_W'(int'(cap_bar_reg) * STEPS_PER_BAR + int'(in_step));
    assign wr_addr = ADDR_W'(int'(cap_idx_reg) * PS + int'(wr_off));

    assign rd_hit = active_reg && step_ok && (rep_bar_reg < BAR_W'(BARS_PER_PHRASE));
    assign rd_off = rd_hit ? OFF_W'(int'(rep_bar_reg) * STEPS_PER_BAR + int'(in_step))
                           : '0;
    assign rd_addr = rd_hit ? ADDR_W'(int'(rep_idx_reg) * PS + int'(rd_off)) : '0;

    assign cap_bar_inc = cap_bar_reg + BAR_W'(1);
    assign rep_bar_inc = rep_bar_reg + BAR_W'(1);
    assign cap_idx_adv = (cap_idx_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                                                                 : cap_idx_reg + IDX_W'(1);

    // bar tick: replay bar advance and end, or capture bar advance, gap count and replay start
    always_comb begin
        cap_idx_next   = cap_idx_reg;
        cap_bar_next   = cap_bar_reg;
        gap_next       = gap_reg;
        active_next    = active_reg;
        rep_idx_next   = rep_idx_reg;
        rep_shift_next = rep_shift_reg;
        rep_bar_next   = rep_bar_reg;
        clear_en       = 1'b0;
        pick           = ring_mod(in_rng[15:8]);
        pick_adj       = pick;
        if (tick_en) begin
            if (active_reg) begin
                rep_bar_next = rep_bar_inc;
                if (rep_bar_inc >= BAR_W'(BARS_PER_PHRASE)) begin
                    active_next  = 1'b0;
                    cap_idx_next = cap_idx_adv;
                    cap_bar_next = '0;
                    clear_en     = 1'b1;
                    gap_next     = '0;
                end
            end else begin
                cap_bar_next = cap_bar_inc;
                if (cap_bar_inc >= BAR_W'(BARS_PER_PHRASE)) begin
                    cap_idx_next = cap_idx_adv;
                    cap_bar_next = '0;
                    clear_en     = 1'b1;
                end
                if (gap_reg != GAP_MAX) begin
                    gap_next = gap_reg + 16'd1;
                end
                // never replay the phrase under capture: step back one entry
                if (pick == cap_idx_next) begin
                    pick_adj = (pick == '0) ? IDX_W'(RING_DEPTH - 1) : pick - IDX_W'(1);
                end
                if ((gap_next >= min_gap_reg) && ({1'b0, in_rng[7:0]} < chance_reg)) begin
                    active_next  = 1'b1;
                    rep_idx_next = pick_adj;
                    rep_bar_next = '0;
                    case (shift_code_t'(in_rng[17:16]))
                        SHIFT_UP:   rep_shift_next = 3'sd2;
                        SHIFT_DOWN: rep_shift_next = -3'sd2;
                        default:    rep_shift_next = 3'sd0;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_gap_reg   <= MIN_GAP_RESET;
            chance_reg    <= CHANCE_RESET;
            cap_idx_reg   <= '0;
            cap_bar_reg   <= '0;
            gap_reg       <= '0;
            active_reg    <= 1'b0;
            rep_idx_reg   <= '0;
            rep_shift_reg <= 3'sd0;
            rep_bar_reg   <= '0;
            valid_reg     <= '{default: '0};
        end else begin
            if (cfg_wr.we) begin
                unique case (cfg_wr.idx)
                    REG_MIN_GAP: min_gap_reg <= cfg_wr.data[15:0];
                    REG_CHANCE:  chance_reg  <= cfg_wr.data[8:0];
                    default:     min_gap_reg <= min_gap_reg;
                endcase
            end
            cap_idx_reg   <= cap_idx_next;
            cap_bar_reg   <= cap_bar_next;
            gap_reg       <= gap_next;
            active_reg    <= active_next;
            rep_idx_reg   <= rep_idx_next;
            rep_shift_reg <= rep_shift_next;
            rep_bar_reg   <= rep_bar_next;
            if (rec_en) begin
                valid_reg[cap_idx_reg][wr_off] <= 1'b1;
            end else if (clear_en) begin
                valid_reg[cap_idx_next] <= '0;
            end
        end
    end

    // phrase memory: one write or one registered read per beat
    always_ff @(posedge aclk) begin
        if (rec_en) begin
            mem[wr_addr] <= in_degree;
        end
        if (query_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_vld_reg   <= valid_reg[rep_idx_reg][rd_off];
            hit_reg      <= rd_hit;
            lk_shift_reg <= rep_shift_reg;
        end
    end

    assign lk_sum  = 9'(int'(rd_data_reg) + 7 + int'(lk_shift_reg));
    assign lk_note = (!hit_reg || !rd_vld_reg || rd_data_reg == NO_NOTE)
                     ? NO_NOTE : {5'd0, mod7(lk_sum)};

    always_ff @(posedge aclk) begin
        if (cmd.load_direct) begin
            note_reg      <= NO_NOTE;
            replaying_reg <= active_next;
        end else if (cmd.load_lookup) begin
            note_reg      <= lk_note;
            replaying_reg <= active_reg;
        end
    end

    assign min_gap       = min_gap_reg | chance_dummy_unused;
    assign chance        = chance_reg;
    assign out_note      = note_reg;
    assign out_replaying = replaying_reg;

endmodule

/* hdl/phrase_capture_replay_ring.sv */
// Phrase capture/replay ring, top level: stream ports, register bus decode.
// Record, tick and idle beats: result registered, valid in the cycle after the input beat.
// Query beats: result passes the registered phrase-memory read, then the result register.
// One beat per cycle while the result stream is not stalled; a query holds off the next beat (one memory port).
// Reset (aresetn low, synchronous): all slots empty, counters and mode cleared,
// registers back to gap 30 and chance 64; no clearing pass needed.
module phrase_capture_replay_ring
    import pcr_pkg::*;
#(
    parameter int RING_DEPTH      = RING_DEPTH_DEF,
    parameter int STEPS_PER_BAR   = STEPS_PER_BAR_DEF,
    parameter int BARS_PER_PHRASE = BARS_PER_PHRASE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [7:0] step, [15:8] degree, [47:16] rng
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] note, [8] replaying, [15:9] zero
    // register bus
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cmd_t        cmd;
    stat_t       stat;
    cfg_wr_t     cfg_wr;
    logic [15:0] min_gap;
    logic [8:0]  chance;
    logic [7:0]  note;
    logic        replaying;
    reg_idx_t    rd_idx;

    // Bus: no wait states; word index sits at paddr[2].
    assign pready      = 1'b1;
    assign cfg_wr.we   = psel && penable && pwrite && pready;
    assign cfg_wr.idx  = reg_idx_t'(paddr[2]);
    assign cfg_wr.data = pwdata;
    assign rd_idx      = reg_idx_t'(paddr[2]);

    always_comb begin
        unique case (rd_idx)
            REG_MIN_GAP: prdata = {16'd0, min_gap};
            REG_CHANCE:  prdata = {23'd0, chance};
            default:     prdata = '0;
        endcase
    end

    // Controller: accepts a beat when the result register is free or
    // draining; a query holds the input during its lookup state.
    pcr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: phrase memory, ring pointers, replay state, result payload.
    pcr_datapath #(
        .RING_DEPTH      (RING_DEPTH),
        .STEPS_PER_BAR   (STEPS_PER_BAR),
        .BARS_PER_PHRASE (BARS_PER_PHRASE)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (s_tuser),
        .in_step       (s_tdata[7:0]),
        .in_degree     (s_tdata[15:8]),
        .in_rng        (s_tdata[47:16]),
        .cfg_wr        (cfg_wr),
        .min_gap       (min_gap),
        .chance        (chance),
        .out_note      (note),
        .out_replaying (replaying)
    );

    assign m_tdata = {7'd0, replaying, note};

endmodule

/* hdl/pcr_checker.sv */
// Port-level checks for the phrase ring, bound to the top level.
// Depends on pcr_pkg.
module pcr_checker
    import pcr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // replayed notes are scale degrees or empty
    a_note_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == NO_NOTE || m_tdata[7:0] < 8'd7))
        else $error("note out of range");

    // a real note only comes out while replaying
    a_note_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:0] != NO_NOTE |-> m_tdata[8])
        else $error("note returned outside replay");

    // gap register reads back what was written
    a_gap_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && !paddr[2]
        |=> (paddr[2] || prdata[15:0] == $past(pwdata[15:0])))
        else $error("gap register readback mismatch");

endmodule

bind phrase_capture_replay_ring pcr_checker u_pcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
